### src/dpsm_pkg.sv
// ----------------------------------------------------------------------------
// Drive power state machine package
// Shared types, command codes and the statusword table used by the drive
// power state machine and its step logic.
// ----------------------------------------------------------------------------
package dpsm_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_CONTROL = 2'd0,
    OP_MODE    = 2'd1,
    OP_TARGET  = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  // Power states; the last three are named but never entered.
  typedef enum logic [2:0] {
    PS_NOT_READY      = 3'd0,
    PS_SO_DISABLED    = 3'd1,
    PS_READY          = 3'd2,
    PS_SWITCHED_ON    = 3'd3,
    PS_OP_ENABLED     = 3'd4,
    PS_QUICK_STOP     = 3'd5,
    PS_FAULT_REACTION = 3'd6,
    PS_FAULT          = 3'd7
  } power_state_e;

  // Controlword commands and bits.
  localparam logic [15:0] CMD_SHUTDOWN  = 16'h0006;
  localparam logic [15:0] CMD_SWITCH_ON = 16'h0007;
  localparam logic [15:0] CMD_ENABLE_OP = 16'h000F;
  localparam int unsigned CW_BIT_NEW    = 4;

  // Statusword bits.
  localparam int unsigned SW_BIT_HOMED   = 12;
  localparam int unsigned SW_BIT_REACHED = 10;

  // Modes of operation.
  localparam logic [7:0] MODE_PP     = 8'd1;
  localparam logic [7:0] MODE_HOMING = 8'd6;

  // Field widths and packed bus widths.
  localparam int unsigned CW_W     = 16;
  localparam int unsigned MODE_W   = 8;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned SW_W     = 16;
  localparam int unsigned IN_DW    = 64;
  localparam int unsigned OUT_DW   = 56;

  // Drive state held between items.
  typedef struct packed {
    power_state_e      power_state;
    logic [MODE_W-1:0] op_mode;
    logic              homing_done;
    logic [CW_W-1:0]   last_control;
    logic [POS_W-1:0]  stored_goal;
    logic [SW_W-1:0]   status_reg;
    logic              enable_reg;
  } drive_state_t;

  // One input item, unpacked.
  typedef struct packed {
    op_e               op;
    logic [CW_W-1:0]   control_word;
    logic [MODE_W-1:0] mode_request;
    logic [POS_W-1:0]  target_position;
    logic              position_reached;
  } drive_item_t;

  // One result item, unpacked.
  typedef struct packed {
    logic [SW_W-1:0]  status_word;
    logic             accepted;
    logic             driver_enable;
    logic             move_start;
    logic [POS_W-1:0] move_goal;
    logic             home_zero;
    logic             status_event;
  } drive_result_t;

  // Base statusword for each power state.
  function automatic logic [SW_W-1:0] base_status(power_state_e ps);
    logic [SW_W-1:0] sw;
    case (ps)
      PS_NOT_READY:      sw = 16'h0000;
      PS_SO_DISABLED:    sw = 16'h0040;
      PS_READY:          sw = 16'h0021;
      PS_SWITCHED_ON:    sw = 16'h0023;
      PS_OP_ENABLED:     sw = 16'h0037;
      PS_QUICK_STOP:     sw = 16'h0007;
      PS_FAULT_REACTION: sw = 16'h000F;
      PS_FAULT:          sw = 16'h0008;
      default:           sw = 16'h0000;
    endcase
    return sw;
  endfunction

endpackage

### src/dpsm_step.sv
// ----------------------------------------------------------------------------
// Drive power state machine step logic
// Combinational next state and result for one item, given the current state.
// ----------------------------------------------------------------------------
module dpsm_step (
  input  dpsm_pkg::drive_state_t  state_i,
  input  dpsm_pkg::drive_item_t   item_i,
  output dpsm_pkg::drive_state_t  state_o,
  output dpsm_pkg::drive_result_t result_o
);
  import dpsm_pkg::*;

  logic            homing_cmd;
  logic            launch;
  power_state_e    ps_next;
  logic            en_next;
  logic [SW_W-1:0] rebuilt;

  // Power state transitions on an exact controlword match.
  always_comb begin
    ps_next = state_i.power_state;
    en_next = state_i.enable_reg;
    case (state_i.power_state)
      PS_SO_DISABLED: begin
        if (item_i.control_word == CMD_SHUTDOWN) ps_next = PS_READY;
      end
      PS_READY: begin
        if (item_i.control_word == CMD_SWITCH_ON) ps_next = PS_SWITCHED_ON;
      end
      PS_SWITCHED_ON: begin
        if (item_i.control_word == CMD_ENABLE_OP) begin
          ps_next = PS_OP_ENABLED;
          en_next = 1'b1;
        end else if (item_i.control_word == CMD_SHUTDOWN) begin
          ps_next = PS_READY;
        end
      end
      PS_OP_ENABLED: begin
        if (item_i.control_word == CMD_SWITCH_ON) begin
          ps_next = PS_SWITCHED_ON;
          en_next = 1'b0;
        end else if (item_i.control_word == CMD_SHUTDOWN) begin
          ps_next = PS_READY;
          en_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Statusword rebuilt from the power state that results from this item.
  function automatic logic [SW_W-1:0] rebuild(power_state_e ps, logic [MODE_W-1:0] mode,
                                              logic homed, logic reached);
    logic [SW_W-1:0] sw;
    sw = base_status(ps);
    if (ps == PS_OP_ENABLED) begin
      if (reached) sw[SW_BIT_REACHED] = 1'b1;
      if (mode == MODE_HOMING && homed) begin
        sw[SW_BIT_HOMED]   = 1'b1;
        sw[SW_BIT_REACHED] = 1'b1;
      end
    end
    return sw;
  endfunction

  assign homing_cmd = (state_i.op_mode == MODE_HOMING) && item_i.control_word[CW_BIT_NEW];
  assign launch     = (state_i.op_mode == MODE_PP) && !state_i.last_control[CW_BIT_NEW]
                      && item_i.control_word[CW_BIT_NEW];

  // Controlword rebuild uses the new state; a refresh uses the current one.
  always_comb begin
    if (item_i.op == OP_CONTROL) begin
      rebuilt = rebuild(ps_next, state_i.op_mode, state_i.homing_done,
                        item_i.position_reached);
    end else begin
      rebuilt = rebuild(state_i.power_state, state_i.op_mode, state_i.homing_done,
                        item_i.position_reached);
    end
  end

  // Per-kind update of the state and the result.
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.accepted = 1'b1;
    case (item_i.op)
      OP_CONTROL: begin
        state_o.last_control = item_i.control_word;
        if (homing_cmd) begin
          result_o.home_zero = 1'b1;
          state_o.homing_done = 1'b1;
          state_o.status_reg[SW_BIT_HOMED]   = 1'b1;
          state_o.status_reg[SW_BIT_REACHED] = 1'b1;
        end else begin
          if (launch) begin
            result_o.move_start = 1'b1;
            result_o.move_goal  = state_i.stored_goal;
          end
          state_o.power_state   = ps_next;
          state_o.enable_reg    = en_next;
          state_o.status_reg    = rebuilt;
          result_o.status_event = 1'b1;
        end
      end
      OP_MODE: begin
        state_o.op_mode = item_i.mode_request;
      end
      OP_TARGET: begin
        if (state_i.power_state != PS_OP_ENABLED) begin
          result_o.accepted = 1'b0;
        end else begin
          state_o.stored_goal = item_i.target_position;
          state_o.status_reg[SW_BIT_REACHED] = 1'b0;
        end
      end
      OP_REFRESH: begin
        state_o.status_reg = rebuilt;
      end
      default: begin
      end
    endcase
    result_o.status_word   = state_o.status_reg;
    result_o.driver_enable = state_o.enable_reg;
  end

endmodule

### src/drive_power_state_machine.sv
// ----------------------------------------------------------------------------
// Drive power state machine
// CiA 402 style power state machine: controlword commands, mode and target
// writes and status refreshes, one result item per input item.
//
//   Channel  Direction  Contents
//   s_axis   in         tuser: op; tdata: controlword, mode, target, reached
//   m_axis   out        tdata: statusword, accepted, enable, start, goal, zero, event
//
// One item per clock cycle unless the output stalls: the drive state updates at the
// accepting edge and the result appears in the output register on the next cycle.
// Reset puts the drive in switch on disabled with all other state cleared.
// A stalled output holds its result; the input is taken again as soon as the
// output register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module drive_power_state_machine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: control_word[15:0], mode_request[23:16], target_position[55:24],
  //        position_reached[56], zero fill above
  input  logic [dpsm_pkg::IN_DW-1:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: status_word[15:0], accepted[16], driver_enable[17], move_start[18],
  //        move_goal[50:19], home_zero[51], status_event[52], zero fill above
  output logic [dpsm_pkg::OUT_DW-1:0] m_axis_tdata
);
  import dpsm_pkg::*;

  drive_state_t  state_q, state_d;
  drive_item_t   item;
  drive_result_t result;
  drive_result_t result_q;
  logic          valid_q;
  logic          take;

  // Input unpacking.
  assign item.op               = op_e'(s_axis_tuser);
  assign item.control_word     = s_axis_tdata[15:0];
  assign item.mode_request     = s_axis_tdata[23:16];
  assign item.target_position  = s_axis_tdata[55:24];
  assign item.position_reached = s_axis_tdata[56];

  dpsm_step u_step (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result)
  );

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  // Drive state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{power_state:  PS_SO_DISABLED,
                   op_mode:      '0,
                   homing_done:  1'b0,
                   last_control: '0,
                   stored_goal:  '0,
                   status_reg:   '0,
                   enable_reg:   1'b0};
    end else if (take) begin
      state_q <= state_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'b000, result_q.status_event, result_q.home_zero,
                          result_q.move_goal, result_q.move_start,
                          result_q.driver_enable, result_q.accepted,
                          result_q.status_word};

endmodule
